>>> hdl/vmix_pkg.sv
// Shared types, constants and codes of the voice mixer.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package vmix_pkg;

   localparam int VOICES = 32;
   localparam int GROUPS = 16;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   localparam int VOL_W   = 24;
   localparam int GAIN_W  = 16;
   localparam int SAMP_W  = 16;
   localparam int FRM_W   = 16;
   localparam int LEVEL_W = 32;
   localparam int SUM_W   = 48;
   localparam int EFF_W   = 28;
   localparam int TERM_W  = 45;
   localparam int DSR_W   = LEVEL_W + 4;

   localparam int QUOT_W    = 17;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam logic [VOL_W-1:0]   VOL_MAX    = 24'hFFFFFF;
   localparam logic [GAIN_W-1:0]  GAIN_UNITY = 16'd4096;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 32'd65536;
   localparam logic [SUM_W-1:0]   SUM_MAX    = 48'h7FFFFFFFFFFF;
   localparam logic [SUM_W-1:0]   SUM_MIN    = 48'h800000000000;
   // floor(n / 5) == (n * RECIP5) >> 34 for any 32-bit n
   localparam logic [31:0]        RECIP5     = 32'hCCCCCCCD;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP  = 1'd1;

   typedef enum logic [1:0] {
      OP_SAMPLE      = 2'd0,
      OP_SET_RAMP    = 2'd1,
      OP_SET_GAIN    = 2'd2,
      OP_EMPTY_FRAME = 2'd3
   } vmix_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RAMP,
      ST_GAIN,
      ST_MIX_RD,
      ST_MIX_EFF,
      ST_MIX_TERM,
      ST_MIX_ACC,
      ST_STEP,
      ST_DECAY,
      ST_DUCK_A,
      ST_DUCK_B,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } vmix_state_type;

   typedef struct packed {
      vmix_op_type               op;
      logic [4:0]                voice;
      logic [3:0]                group;
      logic signed [SAMP_W-1:0]  sample_left;
      logic signed [SAMP_W-1:0]  sample_right;
      logic                      last_voice;
      logic [VOL_W-1:0]          target_left;
      logic [VOL_W-1:0]          target_right;
      logic signed [VOL_W-1:0]   step_left;
      logic signed [VOL_W-1:0]   step_right;
      logic [FRM_W-1:0]          ramp_frames;
      logic [GAIN_W-1:0]         group_gain;
   } vmix_req_type;

   typedef struct packed {
      logic signed [SAMP_W-1:0]  out_left;
      logic signed [SAMP_W-1:0]  out_right;
      logic                      ducking;
      logic [LEVEL_W-1:0]        limiter_level;
   } vmix_rsp_type;

   typedef struct packed {
      logic csr_write;
      logic load;
      logic set_ramp;
      logic set_gain;
      logic mix_rd;
      logic mix_eff;
      logic mix_term;
      logic mix_acc;
      logic ramp_step;
      logic decay;
      logic duck_a;
      logic duck_b;
      logic div_start;
      logic div_store;
      logic out_load;
      logic chan;
   } vmix_cmd_type;

   typedef struct packed {
      vmix_op_type op;
      logic        last_voice;
      logic        voice_ok;
      logic        stereo;
      logic        div_done;
   } vmix_stat_type;

endpackage

`default_nettype wire

>>> hdl/vmix_div.sv
// Restoring divider for the limiter output, one quotient bit per cycle.
// Gives a 16-bit signed quotient, truncated toward zero and saturated. Uses vmix_pkg.
`default_nettype none

module vmix_div import vmix_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [SUM_W-1:0]         dividend,
   input  wire logic [DSR_W-1:0]         divisor,
   input  wire logic                     neg,
   output logic                          done,
   output logic signed [SAMP_W-1:0]      quotient
);

   localparam int DSH_W = DSR_W + QUOT_W - 1;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [DSH_W-1:0]  dsh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              neg_ff;
   logic              ge_in;

   assign ge_in = {{(DSH_W-SUM_W){1'b0}}, rem_ff} >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_STEPS - 1);
            rem_ff  <= dividend;
            dsh_ff  <= {divisor, {(QUOT_W-1){1'b0}}};
            quot_ff <= '0;
            neg_ff  <= neg;
         end else if (busy_ff) begin
            if (ge_in) begin
               rem_ff <= rem_ff - dsh_ff[SUM_W-1:0];
            end
            quot_ff <= {quot_ff[QUOT_W-2:0], ge_in};
            dsh_ff  <= dsh_ff >> 1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // saturate the magnitude, then apply the sign
   always_comb begin
      if (!neg_ff) begin
         if (quot_ff > QUOT_W'(32767)) quotient = 16'sh7FFF;
         else quotient = quot_ff[SAMP_W-1:0];
      end else begin
         if (quot_ff > QUOT_W'(32768)) quotient = 16'sh8000;
         else quotient = -quot_ff[SAMP_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

>>> hdl/vmix_dp.sv
// Datapath of the voice mixer: voice and gain tables, frame sums, limiter, output register.
// Driven by vmix_ctrl through command and status structs; uses vmix_pkg and vmix_div.
`default_nettype none

module vmix_dp import vmix_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vmix_req_type            req_data,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire vmix_cmd_type            cmd,
   output vmix_stat_type                stat,
   output vmix_rsp_type                 rsp_data
);

   vmix_req_type item_ff;
   logic stereo_ff;
   logic [CSR_DATA_W-1:0] decay_ff;

   logic [VOL_W-1:0]        vol_l_ff [VOICES];
   logic [VOL_W-1:0]        vol_r_ff [VOICES];
   logic signed [VOL_W-1:0] stp_l_ff [VOICES];
   logic signed [VOL_W-1:0] stp_r_ff [VOICES];
   logic [VOL_W-1:0]        tgt_l_ff [VOICES];
   logic [VOL_W-1:0]        tgt_r_ff [VOICES];
   logic [FRM_W-1:0]        frm_ff   [VOICES];
   logic [3:0]              grp_ff   [VOICES];
   logic [GAIN_W-1:0]       gain_ff  [GROUPS];

   logic [VOL_W-1:0]         rd_vl_ff, rd_vr_ff;
   logic [GAIN_W-1:0]        rd_gain_ff;
   logic [EFF_W-1:0]         eff_ff, eff_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic [SUM_W-1:0]         sum_l_ff, sum_r_ff, acc_in;
   logic [LEVEL_W-1:0]       level_ff;
   logic                     ducked_ff;
   logic                     gt_ff, gt_in;
   logic [31:0]              y_ff, y_in;
   logic signed [SAMP_W-1:0] out_l_ff, out_r_ff;
   vmix_rsp_type             rsp_ff;

   logic [VIDX_W-1:0] vidx;
   logic [GIDX_W-1:0] gidx;
   logic              voice_ok, group_ok, rd_grp_ok;
   logic [3:0]        rd_grp;
   logic [GAIN_W-1:0] gain_rd;
   logic [VOL_W-1:0]  avg, vsel;
   logic [39:0]       eff_prod;
   logic signed [SAMP_W-1:0] samp;
   logic [SUM_W-1:0]  sum_sel, mag;
   logic [SUM_W:0]    acc_wide;
   logic [51:0]       mag11;
   logic [63:0]       rprod;
   logic [VOL_W-1:0]  vol_l_in, vol_r_in;
   logic signed [SAMP_W-1:0] div_q;
   logic              div_done;

   function automatic logic [VOL_W-1:0] ramp_move(input logic [VOL_W-1:0] vol,
                                                  input logic signed [VOL_W-1:0] step);
      logic signed [VOL_W+1:0] v;
      v = $signed({2'b00, vol}) + (VOL_W+2)'(step);
      if (v < 0) return '0;
      if (v > $signed({2'b00, VOL_MAX})) return VOL_MAX;
      return v[VOL_W-1:0];
   endfunction

   assign vidx      = VIDX_W'(item_ff.voice);
   assign gidx      = GIDX_W'(item_ff.group);
   assign voice_ok  = {27'd0, item_ff.voice} < 32'(VOICES);
   assign group_ok  = {28'd0, item_ff.group} < 32'(GROUPS);
   assign rd_grp    = grp_ff[vidx];
   assign rd_grp_ok = {28'd0, rd_grp} < 32'(GROUPS);
   assign gain_rd   = rd_grp_ok ? gain_ff[GIDX_W'(rd_grp)] : GAIN_UNITY;

   // effective volume and the term for the selected channel
   assign avg      = VOL_W'(({1'b0, rd_vl_ff} + {1'b0, rd_vr_ff}) >> 1);
   assign vsel     = !stereo_ff ? avg : (cmd.chan ? rd_vr_ff : rd_vl_ff);
   assign eff_prod = 40'(vsel) * 40'(rd_gain_ff);
   assign eff_in   = eff_prod[39:12];
   assign samp     = cmd.chan ? item_ff.sample_right : item_ff.sample_left;
   assign term_in  = samp * $signed({1'b0, eff_ff});

   assign sum_sel  = cmd.chan ? sum_r_ff : sum_l_ff;
   assign acc_wide = {sum_sel[SUM_W-1], sum_sel}
                   + {{(SUM_W+1-TERM_W){term_ff[TERM_W-1]}}, term_ff};
   assign acc_in   = (acc_wide[SUM_W] != acc_wide[SUM_W-1])
                   ? (acc_wide[SUM_W] ? SUM_MIN : SUM_MAX) : acc_wide[SUM_W-1:0];

   // limiter: compare |sum| against level and form floor(|sum| * 11 / (10 << 19))
   assign mag   = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
   assign gt_in = {4'd0, mag} > {1'b0, level_ff, 19'd0};
   assign mag11 = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {4'd0, mag};
   assign y_in  = mag11[51:20];
   assign rprod = 64'(y_ff) * 64'(RECIP5);

   // ramp step of the current voice, snapping to target on the final frame
   always_comb begin
      vol_l_in = ramp_move(vol_l_ff[vidx], stp_l_ff[vidx]);
      vol_r_in = ramp_move(vol_r_ff[vidx], stp_r_ff[vidx]);
      if (frm_ff[vidx] == FRM_W'(1)) begin
         vol_l_in = tgt_l_ff[vidx];
         vol_r_in = tgt_r_ff[vidx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b1;
         decay_ff  <= CSR_DATA_W'(1);
      end else if (cmd.csr_write) begin
         case (csr_index)
            CSR_STEREO_MODE: stereo_ff <= csr_wdata[0];
            CSR_DECAY_STEP:  decay_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            vol_l_ff[i] <= '0;
            vol_r_ff[i] <= '0;
            stp_l_ff[i] <= '0;
            stp_r_ff[i] <= '0;
            tgt_l_ff[i] <= '0;
            tgt_r_ff[i] <= '0;
            frm_ff[i]   <= '0;
            grp_ff[i]   <= '0;
         end
      end else if (cmd.set_ramp && voice_ok) begin
         grp_ff[vidx]   <= item_ff.group;
         tgt_l_ff[vidx] <= item_ff.target_left;
         tgt_r_ff[vidx] <= item_ff.target_right;
         stp_l_ff[vidx] <= item_ff.step_left;
         stp_r_ff[vidx] <= item_ff.step_right;
         frm_ff[vidx]   <= item_ff.ramp_frames;
         if (item_ff.ramp_frames == '0) begin
            vol_l_ff[vidx] <= item_ff.target_left;
            vol_r_ff[vidx] <= item_ff.target_right;
         end
      end else if (cmd.ramp_step && frm_ff[vidx] != '0) begin
         vol_l_ff[vidx] <= vol_l_in;
         vol_r_ff[vidx] <= vol_r_in;
         frm_ff[vidx]   <= frm_ff[vidx] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GROUPS; i++) gain_ff[i] <= GAIN_UNITY;
      end else if (cmd.set_gain && group_ok) begin
         gain_ff[gidx] <= item_ff.group_gain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_l_ff  <= '0;
         sum_r_ff  <= '0;
         level_ff  <= LEVEL_ONE;
         ducked_ff <= 1'b0;
      end else begin
         if (cmd.mix_acc) begin
            if (cmd.chan) sum_r_ff <= acc_in;
            else sum_l_ff <= acc_in;
         end
         if (cmd.decay) begin
            ducked_ff <= 1'b0;
            if (level_ff > LEVEL_ONE) begin
               if (level_ff - LEVEL_ONE <= {16'd0, decay_ff}) level_ff <= LEVEL_ONE;
               else level_ff <= level_ff - {16'd0, decay_ff};
            end
         end
         if (cmd.duck_b && gt_ff) begin
            level_ff  <= {2'b00, rprod[63:34]};
            ducked_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            sum_l_ff <= '0;
            sum_r_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.mix_rd) begin
         rd_vl_ff   <= vol_l_ff[vidx];
         rd_vr_ff   <= vol_r_ff[vidx];
         rd_gain_ff <= gain_rd;
      end
      if (cmd.mix_eff) eff_ff <= eff_in;
      if (cmd.mix_term) term_ff <= term_in;
      if (cmd.duck_a) begin
         gt_ff <= gt_in;
         y_ff  <= y_in;
      end
      if (cmd.decay) out_r_ff <= '0;
      if (cmd.div_store) begin
         if (cmd.chan) out_r_ff <= div_q;
         else out_l_ff <= div_q;
      end
      if (cmd.out_load) begin
         rsp_ff.out_left      <= out_l_ff;
         rsp_ff.out_right     <= out_r_ff;
         rsp_ff.ducking       <= ducked_ff;
         rsp_ff.limiter_level <= level_ff;
      end
   end

   vmix_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  ({level_ff, 4'd0}),
      .neg      (sum_sel[SUM_W-1]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign stat.op         = item_ff.op;
   assign stat.last_voice = item_ff.last_voice;
   assign stat.voice_ok   = voice_ok;
   assign stat.stereo     = stereo_ff;
   assign stat.div_done   = div_done;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

>>> hdl/vmix_ctrl.sv
// Controller of the voice mixer: sequences each item through the datapath.
// Owns the handshakes and the output valid; uses vmix_pkg.
`default_nettype none

module vmix_ctrl import vmix_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire vmix_stat_type  stat,
   output vmix_cmd_type        cmd
);

   vmix_state_type state_ff, state_in;
   logic chan_ff, chan_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      cmd           = '0;
      cmd.chan      = chan_ff;
      cmd.csr_write = csr_valid && csr_ready;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            chan_in = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.op)
               OP_SAMPLE: begin
                  if (stat.voice_ok) state_in = ST_MIX_RD;
                  else if (stat.last_voice) state_in = ST_DECAY;
                  else state_in = ST_IDLE;
               end
               OP_SET_RAMP:    state_in = ST_RAMP;
               OP_SET_GAIN:    state_in = ST_GAIN;
               OP_EMPTY_FRAME: state_in = ST_DECAY;
               default:        state_in = ST_IDLE;
            endcase
         end
         ST_RAMP: begin
            cmd.set_ramp = 1'b1;
            state_in = ST_IDLE;
         end
         ST_GAIN: begin
            cmd.set_gain = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MIX_RD: begin
            cmd.mix_rd = 1'b1;
            state_in = ST_MIX_EFF;
         end
         ST_MIX_EFF: begin
            cmd.mix_eff = 1'b1;
            state_in = ST_MIX_TERM;
         end
         ST_MIX_TERM: begin
            cmd.mix_term = 1'b1;
            state_in = ST_MIX_ACC;
         end
         ST_MIX_ACC: begin
            cmd.mix_acc = 1'b1;
            if (!chan_ff && stat.stereo) begin
               chan_in = 1'b1;
               state_in = ST_MIX_EFF;
            end else begin
               chan_in = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.ramp_step = 1'b1;
            state_in = stat.last_voice ? ST_DECAY : ST_IDLE;
         end
         ST_DECAY: begin
            cmd.decay = 1'b1;
            chan_in = 1'b0;
            state_in = ST_DUCK_A;
         end
         ST_DUCK_A: begin
            cmd.duck_a = 1'b1;
            state_in = ST_DUCK_B;
         end
         ST_DUCK_B: begin
            cmd.duck_b = 1'b1;
            // right channel checks against the level the left one left behind
            if (!chan_ff && stat.stereo) begin
               chan_in = 1'b1;
               state_in = ST_DUCK_A;
            end else begin
               chan_in = 1'b0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               if (!chan_ff && stat.stereo) begin
                  chan_in = 1'b1;
                  state_in = ST_DIV_GO;
               end else begin
                  chan_in = 1'b0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted item not decoded");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside wait");

   a_chan_stereo: assert property (@(posedge clock) disable iff (reset)
      chan_ff |-> (stat.stereo && state_ff != ST_IDLE))
      else $error("right channel selected outside a stereo item");

endmodule

`default_nettype wire

>>> hdl/voice_mixer_with_ramps_and_limiter.sv
// Top level of the voice mixer with volume ramps and peak limiter.
// Joins vmix_ctrl and vmix_dp; uses vmix_pkg.
//
// One item is taken at a time. A voice sample runs a shared read, then the volume-gain
// multiply, sample multiply and saturating add steps per channel, plus one ramp step.
// Closing a frame is dominated by the one-bit-per-cycle divider, which forms each
// output over 17 steps. A finished result waits in an output register, so new items
// are taken while it is stalled; a later frame close holds until that register is free.
`default_nettype none

module voice_mixer_with_ramps_and_limiter import vmix_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire vmix_req_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output vmix_rsp_type                rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   vmix_cmd_type  cmd;
   vmix_stat_type stat;

   vmix_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vmix_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/tb_voice_mixer_with_ramps_and_limiter.sv
// Self-checking testbench of the voice mixer with volume ramps and peak limiter.
// Drives random and directed items under random idling, predicts every frame result.
// Depends on vmix_pkg and voice_mixer_with_ramps_and_limiter.
`timescale 1ns / 100ps
`default_nettype none

module tb_voice_mixer_with_ramps_and_limiter;
   import vmix_pkg::*;

   localparam int  LIMIT       = 1_500_000;
   localparam int  TAIL_CYCLES = 80;
   localparam int  PHASE_FRAMES = 70;
   localparam longint SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO   = -64'sh0000_8000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vmix_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vmix_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   voice_mixer_with_ramps_and_limiter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // mixer model state
   logic          mdl_stereo;
   logic [15:0]   mdl_decay;
   logic [23:0]   vol_l [VOICES];
   logic [23:0]   vol_r [VOICES];
   int            stp_l [VOICES];
   int            stp_r [VOICES];
   logic [23:0]   tgt_l [VOICES];
   logic [23:0]   tgt_r [VOICES];
   logic [15:0]   frames_left [VOICES];
   logic [3:0]    grp_of [VOICES];
   logic [15:0]   gains [GROUPS];
   longint        acc_l, acc_r;
   longint        lim_level;

   vmix_req_type  pending_items[$];
   vmix_rsp_type  frame_results[$];

   int  cycles = 0;
   int  mismatches = 0;
   int  items_taken = 0;
   int  frames_seen = 0;
   int  duck_frames = 0;
   bit  took = 0;
   bit  calm = 0;
   int  hold_cnt = 0;
   bit  hold_done = 0;

   function automatic longint sat_sum(longint x);
      if (x > SUM_HI) return SUM_HI;
      if (x < SUM_LO) return SUM_LO;
      return x;
   endfunction

   function automatic logic [23:0] ramp_vol(logic [23:0] v, int s);
      longint n;
      n = longint'(v) + longint'(s);
      if (n < 0) n = 0;
      if (n > 64'hFFFFFF) n = 64'hFFFFFF;
      return n[23:0];
   endfunction

   function automatic bit raise_level(longint s);
      longint mag;
      mag = (s < 0) ? -s : s;
      if (mag > (lim_level << 19)) begin
         lim_level = (mag * 11) / (longint'(10) << 19);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [15:0] scale_out(longint s);
      longint q;
      q = s / (lim_level * 16);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic void mdl_reset();
      mdl_stereo = 1'b1;
      mdl_decay = 16'd1;
      for (int i = 0; i < VOICES; i++) begin
         vol_l[i] = '0; vol_r[i] = '0; stp_l[i] = 0; stp_r[i] = 0;
         tgt_l[i] = '0; tgt_r[i] = '0; frames_left[i] = '0; grp_of[i] = '0;
      end
      for (int g = 0; g < GROUPS; g++) gains[g] = GAIN_UNITY;
      acc_l = 0; acc_r = 0;
      lim_level = 65536;
   endfunction

   function automatic void close_frame();
      vmix_rsp_type r;
      bit d;
      if (lim_level > 65536) begin
         if (lim_level - 65536 <= longint'(mdl_decay)) lim_level = 65536;
         else lim_level -= mdl_decay;
      end
      d = raise_level(acc_l);
      if (mdl_stereo) d = raise_level(acc_r) | d;
      r.out_left = scale_out(acc_l);
      r.out_right = mdl_stereo ? scale_out(acc_r) : 16'd0;
      r.ducking = d;
      r.limiter_level = lim_level[31:0];
      frame_results.insert(frame_results.size(), r);
      acc_l = 0; acc_r = 0;
   endfunction

   function automatic void mix_item(vmix_req_type it);
      int v;
      longint gain, el, er, avg;
      v = it.voice;
      case (it.op)
         OP_SAMPLE: begin
            gain = gains[grp_of[v]];
            if (mdl_stereo) begin
               el = (longint'(vol_l[v]) * gain) >>> 12;
               er = (longint'(vol_r[v]) * gain) >>> 12;
               acc_l = sat_sum(acc_l + longint'(it.sample_left) * el);
               acc_r = sat_sum(acc_r + longint'(it.sample_right) * er);
            end else begin
               avg = (longint'(vol_l[v]) + longint'(vol_r[v])) >>> 1;
               el = (avg * gain) >>> 12;
               acc_l = sat_sum(acc_l + longint'(it.sample_left) * el);
            end
            if (frames_left[v] != 0) begin
               vol_l[v] = ramp_vol(vol_l[v], stp_l[v]);
               vol_r[v] = ramp_vol(vol_r[v], stp_r[v]);
               frames_left[v] = frames_left[v] - 1;
               if (frames_left[v] == 0) begin
                  vol_l[v] = tgt_l[v];
                  vol_r[v] = tgt_r[v];
               end
            end
            if (it.last_voice) close_frame();
         end
         OP_SET_RAMP: begin
            grp_of[v] = it.group;
            tgt_l[v] = it.target_left;
            tgt_r[v] = it.target_right;
            stp_l[v] = int'(it.step_left);
            stp_r[v] = int'(it.step_right);
            frames_left[v] = it.ramp_frames;
            if (it.ramp_frames == 0) begin
               vol_l[v] = it.target_left;
               vol_r[v] = it.target_right;
            end
         end
         OP_SET_GAIN: gains[it.group] = it.group_gain;
         default: close_frame();
      endcase
   endfunction

   function automatic vmix_req_type noise_item();
      vmix_req_type it;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(vmix_req_type)-1:0];
      return it;
   endfunction

   function automatic vmix_req_type sample_item(int v, bit last);
      vmix_req_type it;
      it = noise_item();
      it.op = OP_SAMPLE;
      it.voice = v[4:0];
      it.last_voice = last;
      case ($urandom_range(0, 7))
         0: it.sample_left = 16'sh8000;
         1: it.sample_left = 16'sh7FFF;
         default: ;
      endcase
      return it;
   endfunction

   task automatic queue_frames(int count);
      vmix_req_type it;
      int n;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               it = noise_item();
               it.op = OP_SET_RAMP;
               it.ramp_frames = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                            : 16'($urandom_range(0, 6));
               if ($urandom_range(0, 5) == 0) it.target_left = 24'hFFFFFF;
               pending_items.insert(pending_items.size(), it);
            end
            4, 5: begin
               it = noise_item();
               it.op = OP_SET_GAIN;
               case ($urandom_range(0, 3))
                  0: it.group_gain = 16'hFFFF;
                  1: it.group_gain = 16'h0000;
                  default: ;
               endcase
               pending_items.insert(pending_items.size(), it);
            end
            6: begin
               it = noise_item();
               it.op = OP_EMPTY_FRAME;
               pending_items.insert(pending_items.size(), it);
            end
            7: pending_items.insert(pending_items.size(), noise_item());
            default: begin
               // hold a few voices busy so their ramps keep moving
               n = $urandom_range(1, 8);
               for (int j = 0; j < n; j++)
                  pending_items.insert(pending_items.size(),
                                       sample_item($urandom_range(0, 7), j == n - 1));
            end
         endcase
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_STEREO_MODE) mdl_stereo = val[0];
      else mdl_decay = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid || frame_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) begin
         mix_item(req_data);
         items_taken++;
         took = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || took) begin
         took = 1'b0;
         if (!reset && pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver; one long hold-off fills the block while items keep coming
   always @(negedge clock) begin
      if (!hold_done && items_taken > 300) begin
         hold_done <= 1'b1;
         hold_cnt <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
   end

   always @(posedge clock) begin
      vmix_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         frames_seen++;
         if (frame_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = frame_results.pop_front();
            if (want.ducking) duck_frames++;
            if (rsp_data.out_left !== want.out_left || rsp_data.out_right !== want.out_right
                || rsp_data.ducking !== want.ducking
                || rsp_data.limiter_level !== want.limiter_level) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("frame %0d: expected L %0d R %0d duck %0b lvl %0d",
                           frames_seen, want.out_left, want.out_right, want.ducking,
                           want.limiter_level);
                  $display("   got L %0d R %0d duck %0b lvl %0d",
                           rsp_data.out_left, rsp_data.out_right,
                           rsp_data.ducking, rsp_data.limiter_level);
               end
            end
         end
      end
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      vmix_req_type it;
      mdl_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: loudest voice, full gain, drive the sums into saturation
      it = noise_item();
      it.op = OP_SET_RAMP; it.voice = 0; it.group = 0;
      it.target_left = 24'hFFFFFF; it.target_right = 24'hFFFFFF; it.ramp_frames = 0;
      pending_items.insert(pending_items.size(), it);
      it = noise_item();
      it.op = OP_SET_GAIN; it.group = 0; it.group_gain = 16'hFFFF;
      pending_items.insert(pending_items.size(), it);
      for (int j = 0; j < 18; j++) begin
         it = sample_item(0, j == 17);
         it.sample_left = 16'sh8000;
         it.sample_right = 16'sh7FFF;
         pending_items.insert(pending_items.size(), it);
      end
      it = noise_item(); it.op = OP_EMPTY_FRAME;
      pending_items.insert(pending_items.size(), it);
      it = noise_item();
      it.op = OP_SET_RAMP; it.voice = 31; it.group = 15;
      it.target_left = '0; it.step_left = 24'sh7FFFFF; it.step_right = 24'sh800000;
      it.ramp_frames = 16'd2;
      pending_items.insert(pending_items.size(), it);
      pending_items.insert(pending_items.size(), sample_item(31, 0));
      pending_items.insert(pending_items.size(), sample_item(31, 0));
      pending_items.insert(pending_items.size(), sample_item(31, 1));
      queue_frames(PHASE_FRAMES);
      drain();

      csr_write(CSR_STEREO_MODE, 16'd0);
      csr_write(CSR_DECAY_STEP, 16'd0);
      queue_frames(PHASE_FRAMES);
      drain();

      calm = 1'b1;
      csr_write(CSR_STEREO_MODE, 16'd1);
      csr_write(CSR_DECAY_STEP, 16'hFFFF);
      queue_frames(PHASE_FRAMES);
      drain();
      calm = 1'b0;

      csr_write(CSR_STEREO_MODE, 16'd0);
      queue_frames(PHASE_FRAMES);
      drain();

      csr_write(CSR_STEREO_MODE, 16'd1);
      csr_write(CSR_DECAY_STEP, 16'($urandom_range(1, 4000)));
      queue_frames(PHASE_FRAMES);
      drain();

      $display("%0d items in, %0d frames checked, %0d with limiter raised, %0d cycles",
               items_taken, frames_seen, duck_frames, cycles);
      $display("stereo and mono, decay steps 0 to 65535, ramps, gains and saturation");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hdl/vmix_pkg.sv
hdl/vmix_div.sv
hdl/vmix_dp.sv
hdl/vmix_ctrl.sv
hdl/voice_mixer_with_ramps_and_limiter.sv
tb/tb_voice_mixer_with_ramps_and_limiter.sv
